// ===== design/u2c_pkg.sv =====
// ----------------------------------------------------------------------------
// u2c_pkg
// Shared types and codes for the UTF-8 to CP1252 PDF string transcoder.
// ----------------------------------------------------------------------------
package u2c_pkg;

    localparam int unsigned GRP_MAX = 4;

    // prefix that waits for more bytes
    localparam logic [2:0] PEND_NONE  = 3'd0;
    localparam logic [2:0] PEND_C3    = 3'd1;
    localparam logic [2:0] PEND_C2    = 3'd2;
    localparam logic [2:0] PEND_E2    = 3'd3;
    localparam logic [2:0] PEND_E2_82 = 3'd4;

    localparam logic [7:0] LEAD_C3    = 8'hC3;
    localparam logic [7:0] LEAD_C2    = 8'hC2;
    localparam logic [7:0] LEAD_E2    = 8'hE2;
    localparam logic [7:0] EURO_MID   = 8'h82;
    localparam logic [7:0] EURO_END   = 8'hAC;
    localparam logic [7:0] C3_OFFSET  = 8'h40;
    localparam logic [7:0] CP_EURO    = 8'h80;
    localparam logic [7:0] CH_QMARK   = 8'h3F;
    localparam logic [7:0] CH_LPAREN  = 8'h28;
    localparam logic [7:0] CH_RPAREN  = 8'h29;
    localparam logic [7:0] CH_BSLASH  = 8'h5C;

    typedef struct packed {
        logic [7:0] in_byte;
        logic       end_of_text;
    } in_item_t;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       run_last;
        logic       text_done;
    } out_item_t;

    // bytes produced by one input byte
    typedef struct packed {
        logic [GRP_MAX-1:0][7:0] bytes;
        logic [2:0]              cnt;
    } grp_t;

endpackage

// ===== design/utf8_to_cp1252_pdf_escape_top.sv =====
// An accepted byte passes the input register and then the result register on the way to its first result byte.
// Throughput: one result byte per cycle while res_stall is low; an input byte that
// yields k > 1 bytes holds the input until its group has been handed out.
// The result register serializes each group, one byte per cycle while res_stall is low.
// Reset (rst_n low, asynchronous) empties both stages and clears the prefix.
// ----------------------------------------------------------------------------
// utf8_to_cp1252_pdf_escape_top
// UTF-8 to CP1252 transcoder with PDF string escaping: input register,
// decode and byte group result register.
// ----------------------------------------------------------------------------
module utf8_to_cp1252_pdf_escape_top
    import u2c_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      byte_valid,
    output logic      byte_stall,
    input  in_item_t  byte_data,
    output logic      res_valid,
    input  logic      res_stall,
    output out_item_t res_data
);

    in_item_t   in_reg;
    logic       in_valid_reg;
    logic [2:0] pend_reg;
    logic [2:0] pend_next;
    grp_t       grp;
    logic       grp_free;
    logic       move;

    u2c_decode u_decode (
        .pend      (pend_reg),
        .item      (in_reg),
        .grp       (grp),
        .pend_next (pend_next)
    );

    // prefix-only transactions need no slot in the result register
    assign move       = in_valid_reg && ((grp.cnt == 3'd0) || grp_free);
    assign byte_stall = in_valid_reg && !move;

    u2c_emit u_emit (
        .clk       (clk),
        .rst_n     (rst_n),
        .load      (move && (grp.cnt != 3'd0)),
        .grp       (grp),
        .fin       (in_reg.end_of_text),
        .free      (grp_free),
        .res_valid (res_valid),
        .res_stall (res_stall),
        .res_data  (res_data)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
            pend_reg     <= PEND_NONE;
        end
        else
        begin
            if (!byte_stall)
            begin
                in_valid_reg <= byte_valid;
            end
            if (move)
            begin
                pend_reg <= pend_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (byte_valid && !byte_stall)
        begin
            in_reg <= byte_data;
        end
    end

`ifndef SYNTHESIS
    a_pend_range: assert property (@(posedge clk) disable iff (!rst_n)
        pend_reg == PEND_NONE || pend_reg == PEND_C3 || pend_reg == PEND_C2 ||
        pend_reg == PEND_E2 || pend_reg == PEND_E2_82)
        else $error("prefix register holds an unused code");

    a_end_clears: assert property (@(posedge clk) disable iff (!rst_n)
        (move && in_reg.end_of_text) |=> pend_reg == PEND_NONE)
        else $error("prefix left pending after end of text");

    a_end_has_result: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid_reg && in_reg.end_of_text) |-> grp.cnt != 3'd0)
        else $error("end of text produced no result");
`endif

endmodule

// ===== design/u2c_decode.sv =====
// ----------------------------------------------------------------------------
// u2c_decode
// Maps one UTF-8 byte and the pending prefix to a group of CP1252 bytes.
// ----------------------------------------------------------------------------
module u2c_decode
    import u2c_pkg::*;
(
    input  logic [2:0] pend,
    input  in_item_t   item,
    output grp_t       grp,
    output logic [2:0] pend_next
);

    logic [7:0] b;
    logic       fin;
    logic       is_esc;
    logic [1:0] lead_cnt;
    logic [7:0] lead0;
    logic [7:0] lead1;
    logic [2:0] lead_pend;

    assign b   = item.in_byte;
    assign fin = item.end_of_text;
    assign is_esc = (b == CH_LPAREN) || (b == CH_RPAREN) || (b == CH_BSLASH);

    // byte taken as the start of a new character
    always_comb
    begin
        lead_cnt  = 2'd1;
        lead0     = CH_QMARK;
        lead1     = b;
        lead_pend = PEND_NONE;
        if (!b[7])
        begin
            lead_cnt = is_esc ? 2'd2 : 2'd1;
            lead0    = is_esc ? CH_BSLASH : b;
        end
        else if (!fin && b == LEAD_C3)
        begin
            lead_cnt  = 2'd0;
            lead_pend = PEND_C3;
        end
        else if (!fin && b == LEAD_C2)
        begin
            lead_cnt  = 2'd0;
            lead_pend = PEND_C2;
        end
        else if (!fin && b == LEAD_E2)
        begin
            lead_cnt  = 2'd0;
            lead_pend = PEND_E2;
        end
    end

    always_comb
    begin
        grp.bytes = '0;
        grp.cnt   = 3'd0;
        pend_next = PEND_NONE;
        unique case (pend)
            PEND_C3:
            begin
                grp.bytes[0] = b + C3_OFFSET;
                grp.cnt      = 3'd1;
            end
            PEND_C2:
            begin
                grp.bytes[0] = b;
                grp.cnt      = 3'd1;
            end
            PEND_E2:
            begin
                if (b == EURO_MID && !fin)
                begin
                    pend_next = PEND_E2_82;
                end
                else
                begin
                    grp.bytes[0] = CH_QMARK;
                    grp.bytes[1] = lead0;
                    grp.bytes[2] = lead1;
                    grp.cnt      = 3'd1 + {1'b0, lead_cnt};
                    pend_next    = lead_pend;
                end
            end
            PEND_E2_82:
            begin
                if (b == EURO_END)
                begin
                    grp.bytes[0] = CP_EURO;
                    grp.cnt      = 3'd1;
                end
                else
                begin
                    // broken euro sequence: one mark for each stored byte
                    grp.bytes[0] = CH_QMARK;
                    grp.bytes[1] = CH_QMARK;
                    grp.bytes[2] = lead0;
                    grp.bytes[3] = lead1;
                    grp.cnt      = 3'd2 + {1'b0, lead_cnt};
                    pend_next    = lead_pend;
                end
            end
            default:
            begin
                grp.bytes[0] = lead0;
                grp.bytes[1] = lead1;
                grp.cnt      = {1'b0, lead_cnt};
                pend_next    = lead_pend;
            end
        endcase
    end

endmodule

// ===== design/u2c_emit.sv =====
// ----------------------------------------------------------------------------
// u2c_emit
// Result register: holds one byte group and hands it out a byte per cycle while res_stall is low.
// ----------------------------------------------------------------------------
module u2c_emit
    import u2c_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      load,
    input  grp_t      grp,
    input  logic      fin,
    output logic      free,
    output logic      res_valid,
    input  logic      res_stall,
    output out_item_t res_data
);

    grp_t       grp_reg;
    logic       fin_reg;
    logic       valid_reg;
    logic [1:0] pos_reg;
    logic [1:0] pos_next;
    logic       last;

    assign last     = ({1'b0, pos_reg} == (grp_reg.cnt - 3'd1));
    assign free     = !valid_reg || (last && !res_stall);
    assign pos_next = pos_reg + 2'd1;

    assign res_valid          = valid_reg;
    assign res_data.out_byte  = grp_reg.bytes[pos_reg];
    assign res_data.run_last  = last;
    assign res_data.text_done = last && fin_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            pos_reg   <= 2'd0;
        end
        else if (load)
        begin
            valid_reg <= 1'b1;
            pos_reg   <= 2'd0;
        end
        else if (valid_reg && !res_stall)
        begin
            if (last)
            begin
                valid_reg <= 1'b0;
            end
            else
            begin
                pos_reg <= pos_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            grp_reg <= grp;
            fin_reg <= fin;
        end
    end

`ifndef SYNTHESIS
    a_group_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        valid_reg |-> (grp_reg.cnt != 3'd0 && {1'b0, pos_reg} < grp_reg.cnt))
        else $error("result group empty or position past its end");

    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        load |-> (!valid_reg || (last && !res_stall)))
        else $error("group loaded over bytes not yet delivered");

    a_pos_step: assert property (@(posedge clk) disable iff (!rst_n)
        (valid_reg && !res_stall && !last && !load) |=> pos_reg == $past(pos_next))
        else $error("position did not advance after a transaction");
`endif

endmodule
